FILE: rtl/core/dpfd_pkg.sv
// shared types, constants and helpers for the debounced power-fail detector
// no dependencies; imported by every rtl module and the checker
package dpfd_pkg;

   localparam int unsigned SeqWidth     = 32;
   localparam int unsigned MvWidth      = 16;
   localparam int unsigned StampWidth   = 63;
   localparam int unsigned RunWidth     = 8;
   localparam int unsigned EvNumWidth   = 32;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned ReqDataWidth = 96;
   localparam int unsigned RspDataWidth = 136;

   typedef enum logic [1:0] {
      PWR_UNKNOWN = 2'd0,
      PWR_OK      = 2'd1,
      PWR_LOST    = 2'd2
   } power_state_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_LOST     = 2'd1,
      EV_RESTORED = 2'd2,
      EV_BKLOW    = 2'd3
   } event_kind_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LOST_LEVEL     = 3'd0,
      CSR_RESTORE_LEVEL  = 3'd1,
      CSR_DEBOUNCE       = 3'd2,
      CSR_BACKUP_PRESENT = 3'd3,
      CSR_BACKUP_LOW     = 3'd4
   } csr_index_type;

   localparam logic [MvWidth-1:0]  LostLevelReset     = 16'd10500;
   localparam logic [MvWidth-1:0]  RestoreLevelReset  = 16'd11500;
   localparam logic [RunWidth-1:0] DebounceReset      = 8'd3;
   localparam logic [MvWidth-1:0]  BackupPresentReset = 16'd2000;
   localparam logic [MvWidth-1:0]  BackupLowReset     = 16'd3300;

   // one classified sample, carries up to two results
   typedef struct packed {
      power_state_type          state;
      event_kind_type           kind0;
      logic [EvNumWidth-1:0]    num0;
      logic                     two;
      logic [EvNumWidth-1:0]    num1;
      logic [MvWidth-1:0]       main_mv;
      logic [MvWidth-1:0]       backup_mv;
      logic [StampWidth-1:0]    stamp_us;
   } entry_type;

   typedef struct packed {
      logic      not_empty;
      logic      full;
   } queue_status_type;

   function automatic logic [RunWidth-1:0] run_inc(logic [RunWidth-1:0] r);
      return (r == {RunWidth{1'b1}}) ? r : r + RunWidth'(1);
   endfunction

   function automatic logic [EvNumWidth-1:0] ev_num_out(logic [SeqWidth-1:0] s);
      logic [63:0] w;
      w = 64'(s);
      return w[EvNumWidth-1:0];
   endfunction

endpackage

FILE: rtl/core/debounced_power_fail_detector_unit.sv
// top level of the debounced power-fail detector
// depends on dpfd_pkg, dpfd_front, dpfd_queue and dpfd_back
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tdata: main_mv, backup_mv, stamp_us
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata, tuser: event_kind, tlast
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// one sample is accepted per cycle while the two-entry queue has room
// the back part emits one result per cycle from its output register while rsp_tready is high
// a sample with a restore and a backup-low event holds the queue head until its second result is loaded
// reset returns the power state to unknown and the configuration registers to defaults
// rsp_tready low fills the queue, after which req_tready drops
module debounced_power_fail_detector_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // main_mv[15:0], backup_mv[31:16], stamp_us[94:32], pad[95]
   input  logic [dpfd_pkg::ReqDataWidth-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // power_state[1:0], main_echo_mv[17:2], backup_echo_mv[33:18],
   // stamp_echo_us[96:34], event_number[128:97], pad[135:129]
   output logic [dpfd_pkg::RspDataWidth-1:0]    rsp_tdata,
   // event_kind[1:0]
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dpfd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [dpfd_pkg::MvWidth-1:0]         csr_data
);
   import dpfd_pkg::*;

   logic             push, pop;
   entry_type        push_entry, head;
   queue_status_type q_status;

   dpfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   dpfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   dpfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/dpfd_front.sv
// front part: configuration registers, sample acceptance and state tracking
// depends on dpfd_pkg; feeds classified entries into dpfd_queue
module dpfd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dpfd_pkg::ReqDataWidth-1:0]    req_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dpfd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [dpfd_pkg::MvWidth-1:0]         csr_data,
   input  dpfd_pkg::queue_status_type           q_status,
   output logic                                 push,
   output dpfd_pkg::entry_type                  push_entry
);
   import dpfd_pkg::*;

   logic [MvWidth-1:0]    lost_level_ff, restore_level_ff, bk_present_ff, bk_low_ff;
   logic [RunWidth-1:0]   debounce_ff;
   power_state_type       state_ff, state_in;
   logic [RunWidth-1:0]   lost_run_ff, lost_run_in, restore_run_ff, restore_run_in;
   logic                  sent_ff, sent_in;
   logic [SeqWidth-1:0]   seq_ff, seq_in;
   logic [RunWidth-1:0]   run_next;
   logic [1:0]            nev;
   event_kind_type        kind0;
   logic                  two;
   logic [MvWidth-1:0]    main_mv, backup_mv;
   logic [StampWidth-1:0] stamp_us;

   assign main_mv    = req_tdata[15:0];
   assign backup_mv  = req_tdata[31:16];
   assign stamp_us   = req_tdata[94:32];
   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lost_level_ff    <= LostLevelReset;
         restore_level_ff <= RestoreLevelReset;
         debounce_ff      <= DebounceReset;
         bk_present_ff    <= BackupPresentReset;
         bk_low_ff        <= BackupLowReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOST_LEVEL:     lost_level_ff    <= csr_data;
            CSR_RESTORE_LEVEL:  restore_level_ff <= csr_data;
            CSR_DEBOUNCE:       debounce_ff      <= csr_data[RunWidth-1:0];
            CSR_BACKUP_PRESENT: bk_present_ff    <= csr_data;
            CSR_BACKUP_LOW:     bk_low_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= PWR_UNKNOWN;
         lost_run_ff    <= '0;
         restore_run_ff <= '0;
         sent_ff        <= 1'b0;
         seq_ff         <= '0;
      end else if (push) begin
         state_ff       <= state_in;
         lost_run_ff    <= lost_run_in;
         restore_run_ff <= restore_run_in;
         sent_ff        <= sent_in;
         seq_ff         <= seq_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      lost_run_in    = lost_run_ff;
      restore_run_in = restore_run_ff;
      sent_in        = sent_ff;
      kind0          = EV_NONE;
      two            = 1'b0;
      nev            = 2'd0;
      run_next       = '0;
      case (state_ff)
         PWR_UNKNOWN: begin
            if (main_mv >= restore_level_ff) begin
               state_in = PWR_OK;
            end else if (main_mv <= lost_level_ff) begin
               state_in = PWR_LOST;
            end
         end
         PWR_OK: begin
            if (main_mv < lost_level_ff) begin
               run_next       = run_inc(lost_run_ff);
               lost_run_in    = run_next;
               restore_run_in = '0;
               if (run_next >= debounce_ff) begin
                  state_in    = PWR_LOST;
                  lost_run_in = '0;
                  sent_in     = 1'b0;
                  kind0       = EV_LOST;
                  nev         = 2'd1;
               end
            end else begin
               lost_run_in = '0;
            end
         end
         PWR_LOST: begin
            if (main_mv > restore_level_ff) begin
               run_next       = run_inc(restore_run_ff);
               restore_run_in = run_next;
               lost_run_in    = '0;
               if (run_next >= debounce_ff) begin
                  state_in       = PWR_OK;
                  restore_run_in = '0;
                  sent_in        = 1'b0;
                  kind0          = EV_RESTORED;
                  nev            = 2'd1;
               end
            end else begin
               restore_run_in = '0;
            end
            if (backup_mv > bk_present_ff && backup_mv < bk_low_ff && !sent_in) begin
               sent_in = 1'b1;
               if (kind0 == EV_NONE) begin
                  kind0 = EV_BKLOW;
                  nev   = 2'd1;
               end else begin
                  two = 1'b1;
                  nev = 2'd2;
               end
            end
         end
         default: ;
      endcase
      seq_in = seq_ff + SeqWidth'(nev);
   end

   always_comb begin
      push_entry.state     = state_in;
      push_entry.kind0     = kind0;
      push_entry.num0      = (kind0 != EV_NONE) ? ev_num_out(seq_ff) : '0;
      push_entry.two       = two;
      push_entry.num1      = ev_num_out(seq_ff + SeqWidth'(1));
      push_entry.main_mv   = main_mv;
      push_entry.backup_mv = backup_mv;
      push_entry.stamp_us  = stamp_us;
   end

endmodule

FILE: rtl/core/dpfd_queue.sv
// two-entry queue between the front and back parts
// depends on dpfd_pkg for the entry and status types
module dpfd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  dpfd_pkg::entry_type         push_entry,
   input  logic                        pop,
   output dpfd_pkg::entry_type         head,
   output dpfd_pkg::queue_status_type  status
);
   import dpfd_pkg::*;

   entry_type  mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign head             = mem_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != 2'd0);
   assign status.full      = (count_ff == 2'd2);

endmodule

FILE: rtl/core/dpfd_back.sv
// back part: turns queued entries into one or two results in an output register
// depends on dpfd_pkg; reads the head of dpfd_queue
module dpfd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dpfd_pkg::entry_type                  head,
   input  dpfd_pkg::queue_status_type           q_status,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dpfd_pkg::RspDataWidth-1:0]    rsp_tdata,
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast
);
   import dpfd_pkg::*;

   logic                   valid_ff;
   logic                   phase_ff, phase_in;
   logic                   load;
   event_kind_type         kind_ff, kind_in;
   logic [EvNumWidth-1:0]  num_ff, num_in;
   logic                   last_ff, last_in;
   power_state_type        state_ff;
   logic [MvWidth-1:0]     main_ff, backup_ff;
   logic [StampWidth-1:0]  stamp_ff;

   assign load = q_status.not_empty && (!valid_ff || rsp_tready);

   always_comb begin
      if (phase_ff) begin
         kind_in  = EV_BKLOW;
         num_in   = head.num1;
         last_in  = 1'b1;
         phase_in = 1'b0;
         pop      = load;
      end else begin
         kind_in  = head.kind0;
         num_in   = head.num0;
         last_in  = !head.two;
         phase_in = head.two;
         pop      = load && !head.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
         phase_ff <= phase_in;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         num_ff    <= num_in;
         last_ff   <= last_in;
         state_ff  <= head.state;
         main_ff   <= head.main_mv;
         backup_ff <= head.backup_mv;
         stamp_ff  <= head.stamp_us;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, num_ff, stamp_ff, backup_ff, main_ff, state_ff};

endmodule

FILE: rtl/core/dpfd_checker.sv
// port-level checks for the debounced power-fail detector
// depends on dpfd_pkg; bound to debounced_power_fail_detector_unit below
module dpfd_port_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [dpfd_pkg::ReqDataWidth-1:0]    req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [dpfd_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  logic [1:0]                           rsp_tuser,
   input  logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [dpfd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [dpfd_pkg::MvWidth-1:0]         csr_data
);
   import dpfd_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // only a restore is followed by a second result
   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == EV_RESTORED)
      else $error("non-final result is not a restore");

   // status-only results carry no event number
   a_no_event_num: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_NONE |-> rsp_tdata[128:97] == '0)
      else $error("event number on a status-only result");

   // event kind agrees with reported state
   a_event_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_LOST || rsp_tuser == EV_RESTORED)
         |-> rsp_tdata[1:0] == ((rsp_tuser == EV_LOST) ? PWR_LOST : PWR_OK))
      else $error("event kind does not match power state");

endmodule

bind debounced_power_fail_detector_unit dpfd_port_checker u_dpfd_port_checker (.*);
